[hdl/hydrogen_bond_geometry_test_assert.svh]
// ----------------------------------------------------------------------------
// Hydrogen bond geometry test - assertion macros
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HYDROGEN_BOND_GEOMETRY_TEST_ASSERT_SVH
`define HYDROGEN_BOND_GEOMETRY_TEST_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define HBG_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("hbg assertion failed");
// next-cycle implication
`define HBG_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("hbg assertion failed");
`else
`define HBG_ASSERT_IMP(lbl, ant, con)
`define HBG_ASSERT_NXT(lbl, ant, con)
`endif

`endif

[hdl/hbg_pkg.sv]
// ----------------------------------------------------------------------------
// hbg_pkg
// Shared types and constants of the hydrogen bond geometry test.
// ----------------------------------------------------------------------------
`default_nettype none

package hbg_pkg;

    // configuration register widths
    localparam int CFG_W     = 48;
    localparam int COS_W     = 16;
    localparam int CFG_IDX_W = 2;
    // |cos|^2 needs 31 bits (max 2^30)
    localparam int C2_W      = 31;
    // Q1.15 squared: the dot term is scaled by 2^30
    localparam int COS_SH    = 30;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS   = 2'd2;

    // reset values
    localparam logic [CFG_W-1:0]        INNER_RST = 48'd0;
    localparam logic [CFG_W-1:0]        OUTER_RST = 48'd3670016;
    localparam logic signed [COS_W-1:0] COS_RST   = 16'sd30792;

    typedef struct packed {
        logic [CFG_W-1:0]        inner;
        logic [CFG_W-1:0]        outer;
        logic signed [COS_W-1:0] cos_dev;
    } t_cfg;

    // per-item decisions carried down the pipeline
    typedef struct packed {
        logic dist_ok;
        logic dnonpos;   // a.b <= 0
        logic zero;      // a or b is the zero vector
    } t_flags;

endpackage

`default_nettype wire

[hdl/hbg_cfg.sv]
// ----------------------------------------------------------------------------
// hbg_cfg
// Configuration registers and the registered square of |cos_deviation|.
// ----------------------------------------------------------------------------
`default_nettype none

module hbg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hbg_pkg::CFG_W-1:0]     i_cfg_data,
    output hbg_pkg::t_cfg                 o_cfg,
    output logic [hbg_pkg::C2_W-1:0]      o_cos_sq
);
    import hbg_pkg::*;

    t_cfg                r_cfg;
    logic [C2_W-1:0]     r_cos_sq;
    logic [COS_W-1:0]    w_cmag;
    logic [2*COS_W-1:0]  w_sq;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inner   <= INNER_RST;
            r_cfg.outer   <= OUTER_RST;
            r_cfg.cos_dev <= COS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INNER: r_cfg.inner   <= i_cfg_data;
                REG_OUTER: r_cfg.outer   <= i_cfg_data;
                REG_COS:   r_cfg.cos_dev <= $signed(i_cfg_data[COS_W-1:0]);
                default: ;
            endcase
        end
    end

    // |C|^2, -32768 gives 2^30
    assign w_cmag = r_cfg.cos_dev[COS_W-1] ? COS_W'(-r_cfg.cos_dev)
                                           : COS_W'(r_cfg.cos_dev);
    assign w_sq   = w_cmag * w_cmag;

    always_ff @(posedge i_clk) begin
        r_cos_sq <= w_sq[C2_W-1:0];
    end

    assign o_cfg    = r_cfg;
    assign o_cos_sq = r_cos_sq;

endmodule

`default_nettype wire

[hdl/hbg_mul.sv]
// ----------------------------------------------------------------------------
// hbg_mul
// Two-stage unsigned multiplier: chunked partial products, then shifted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hbg_mul #(
    parameter int WA = 50,
    parameter int WB = 50,
    parameter int CA = 25,
    parameter int CB = 25
) (
    input  logic             i_clk,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);
    localparam int NA = (WA + CA - 1) / CA;
    localparam int NB = (WB + CB - 1) / CB;
    localparam int PW = NA * CA + NB * CB;

    logic [NA*CA-1:0]    w_a;
    logic [NB*CB-1:0]    w_b;
    logic [CA+CB-1:0]    r_pp [NA][NB];
    logic [PW-1:0]       w_sum;
    logic [WA+WB-1:0]    r_p;

    assign w_a = (NA*CA)'(i_a);
    assign w_b = (NB*CB)'(i_b);

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= w_a[i*CA +: CA] * w_b[j*CB +: CB];
            end
        end
    end

    // stage 2: align and add
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                w_sum = w_sum + (PW'(r_pp[i][j]) << (i*CA + j*CB));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_sum[WA+WB-1:0];
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[hdl/hbg_front.sv]
// ----------------------------------------------------------------------------
// hbg_front
// Vector setup, component products, norms and dot product, distance test.
// Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hbg_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_BITS-1:0]  i_donor_x,
    input  logic signed [COORD_BITS-1:0]  i_donor_y,
    input  logic signed [COORD_BITS-1:0]  i_donor_z,
    input  logic signed [COORD_BITS-1:0]  i_hyd_x,
    input  logic signed [COORD_BITS-1:0]  i_hyd_y,
    input  logic signed [COORD_BITS-1:0]  i_hyd_z,
    input  logic signed [COORD_BITS-1:0]  i_acc_x,
    input  logic signed [COORD_BITS-1:0]  i_acc_y,
    input  logic signed [COORD_BITS-1:0]  i_acc_z,
    input  hbg_pkg::t_cfg                 i_cfg,
    output logic                          o_vld,
    output hbg_pkg::t_flags               o_flags,
    output logic [2*COORD_BITS+1:0]       o_dmag,
    output logic [2*COORD_BITS+1:0]       o_na,
    output logic [2*COORD_BITS+1:0]       o_nb
);
    import hbg_pkg::*;

    localparam int DW   = COORD_BITS + 1;      // difference width
    localparam int NW   = 2 * COORD_BITS + 2;  // norm / |dot| width
    localparam int CMPW = (NW > CFG_W) ? NW : CFG_W;

    logic signed [COORD_BITS-1:0] w_d [3];
    logic signed [COORD_BITS-1:0] w_h [3];
    logic signed [COORD_BITS-1:0] w_c [3];

    logic [3:0]            r_vld;
    logic signed [DW-1:0]  r_a  [3];
    logic signed [DW-1:0]  r_b  [3];
    logic signed [NW-1:0]  r_aa [3];
    logic signed [NW-1:0]  r_bb [3];
    logic signed [NW-1:0]  r_ab [3];
    logic [NW-1:0]         r_na;
    logic [NW-1:0]         r_nb;
    logic signed [NW:0]    r_dot;

    logic [NW:0]           w_dneg;
    logic [CMPW-1:0]       w_nb_c;
    t_flags                n_flags;
    t_flags                r_flags;
    logic [NW-1:0]         r_dmag;
    logic [NW-1:0]         r_na4;
    logic [NW-1:0]         r_nb4;

    assign w_d = '{i_donor_x, i_donor_y, i_donor_z};
    assign w_h = '{i_hyd_x,   i_hyd_y,   i_hyd_z};
    assign w_c = '{i_acc_x,   i_acc_y,   i_acc_z};

    // beat valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    // stage 1: a = D - H, b = A - H
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a[i] <= DW'(w_d[i]) - DW'(w_h[i]);
            r_b[i] <= DW'(w_c[i]) - DW'(w_h[i]);
        end
    end

    // stage 2: component products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_aa[i] <= r_a[i] * r_a[i];
            r_bb[i] <= r_b[i] * r_b[i];
            r_ab[i] <= r_a[i] * r_b[i];
        end
    end

    // stage 3: |a|^2, |b|^2, a.b
    always_ff @(posedge i_clk) begin
        r_na  <= $unsigned(r_aa[0]) + $unsigned(r_aa[1]) + $unsigned(r_aa[2]);
        r_nb  <= $unsigned(r_bb[0]) + $unsigned(r_bb[1]) + $unsigned(r_bb[2]);
        r_dot <= (NW+1)'(r_ab[0]) + (NW+1)'(r_ab[1]) + (NW+1)'(r_ab[2]);
    end

    // stage 4: distance window, dot sign and magnitude, zero vectors
    assign w_dneg = $unsigned(-r_dot);
    assign w_nb_c = CMPW'(r_nb);

    always_comb begin
        n_flags.dist_ok = (w_nb_c >= CMPW'(i_cfg.inner)) && (w_nb_c <= CMPW'(i_cfg.outer));
        n_flags.dnonpos = r_dot[NW] || (r_dot == '0);
        n_flags.zero    = (r_na == '0) || (r_nb == '0);
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_dmag  <= r_dot[NW] ? w_dneg[NW-1:0] : $unsigned(r_dot[NW-1:0]);
        r_na4   <= r_na;
        r_nb4   <= r_nb;
    end

    assign o_vld   = r_vld[3];
    assign o_flags = r_flags;
    assign o_dmag  = r_dmag;
    assign o_na    = r_na4;
    assign o_nb    = r_nb4;

endmodule

`default_nettype wire

[hdl/hydrogen_bond_geometry_test.sv]
// ----------------------------------------------------------------------------
// hydrogen_bond_geometry_test
// Donor-hydrogen-acceptor geometric criterion: distance window on |H-A|^2
// and an angle test done as an exact squared comparison, one triple a clock.
//
//   channel   signals                                   handshake
//   --------  ----------------------------------------  -------------------
//   command   i_donor_*, i_hyd_*, i_acc_*               start & !busy
//   result    o_bonded, o_dist_ok, o_angle_ok           o_valid, 1 cycle
//   config    i_cfg_index, i_cfg_data                   i_cfg_valid & o_cfg_ready
//
// Nine-stage pipeline: each start gives one result beat on o_valid.
// A new triple is taken every clock; busy stays low. The depth is set by the
// chunked wide products (D^2, |a|^2|b|^2, then times cos^2).
// Synchronous active-low reset clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hydrogen_bond_geometry_test_assert.svh"

module hydrogen_bond_geometry_test #(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  i_donor_x,
    input  logic signed [COORD_BITS-1:0]  i_donor_y,
    input  logic signed [COORD_BITS-1:0]  i_donor_z,
    input  logic signed [COORD_BITS-1:0]  i_hyd_x,
    input  logic signed [COORD_BITS-1:0]  i_hyd_y,
    input  logic signed [COORD_BITS-1:0]  i_hyd_z,
    input  logic signed [COORD_BITS-1:0]  i_acc_x,
    input  logic signed [COORD_BITS-1:0]  i_acc_y,
    input  logic signed [COORD_BITS-1:0]  i_acc_z,
    output logic                          o_valid,
    output logic                          o_bonded,
    output logic                          o_dist_ok,
    output logic                          o_angle_ok,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hbg_pkg::CFG_W-1:0]     i_cfg_data
);
    import hbg_pkg::*;

    localparam int NW  = 2 * COORD_BITS + 2;
    localparam int CH  = (NW + 1) / 2;          // chunk for NW x NW products
    localparam int PW  = 2 * NW;                // NW x NW product width
    localparam int CR  = (PW + 3) / 4;          // chunk for the cos^2 product
    localparam int RW  = PW + C2_W;             // compare width

    t_cfg               w_cfg;
    logic [C2_W-1:0]    w_cos_sq;

    logic               w_vld4;
    t_flags             w_flags4;
    logic [NW-1:0]      w_dmag4;
    logic [NW-1:0]      w_na4;
    logic [NW-1:0]      w_nb4;

    logic [PW-1:0]      w_l6;
    logic [PW-1:0]      w_r16;
    logic [RW-1:0]      w_r8;

    logic [3:0]         r_vld;
    t_flags             r_fl [4];
    logic [PW-1:0]      r_l7;
    logic [PW-1:0]      r_l8;

    logic [RW-1:0]      w_lhs;
    logic               w_ge;
    logic               w_le;
    logic               n_angle_ok;
    logic               r_out_vld;
    logic               r_bonded;
    logic               r_dist_ok;
    logic               r_angle_ok;

    // fully pipelined, never holds off a command
    assign busy = 1'b0;

    hbg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_cos_sq    (w_cos_sq)
    );

    // stages 1-4
    hbg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start & ~busy),
        .i_donor_x (i_donor_x),
        .i_donor_y (i_donor_y),
        .i_donor_z (i_donor_z),
        .i_hyd_x   (i_hyd_x),
        .i_hyd_y   (i_hyd_y),
        .i_hyd_z   (i_hyd_z),
        .i_acc_x   (i_acc_x),
        .i_acc_y   (i_acc_y),
        .i_acc_z   (i_acc_z),
        .i_cfg     (w_cfg),
        .o_vld     (w_vld4),
        .o_flags   (w_flags4),
        .o_dmag    (w_dmag4),
        .o_na      (w_na4),
        .o_nb      (w_nb4)
    );

    // stages 5-6: D^2
    hbg_mul #(
        .WA (NW), .WB (NW), .CA (CH), .CB (CH)
    ) u_mul_l (
        .i_clk (i_clk),
        .i_a   (w_dmag4),
        .i_b   (w_dmag4),
        .o_p   (w_l6)
    );

    // stages 5-6: |a|^2 * |b|^2
    hbg_mul #(
        .WA (NW), .WB (NW), .CA (CH), .CB (CH)
    ) u_mul_r1 (
        .i_clk (i_clk),
        .i_a   (w_na4),
        .i_b   (w_nb4),
        .o_p   (w_r16)
    );

    // stages 7-8: |a|^2|b|^2 * C^2
    hbg_mul #(
        .WA (PW), .WB (C2_W), .CA (CR), .CB (C2_W)
    ) u_mul_r (
        .i_clk (i_clk),
        .i_a   (w_r16),
        .i_b   (w_cos_sq),
        .o_p   (w_r8)
    );

    // valid bits for stages 5-8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], w_vld4};
        end
    end

    // flags and D^2 ride along to stage 8
    always_ff @(posedge i_clk) begin
        r_fl[0] <= w_flags4;
        r_fl[1] <= r_fl[0];
        r_fl[2] <= r_fl[1];
        r_fl[3] <= r_fl[2];
        r_l7    <= w_l6;
        r_l8    <= r_l7;
    end

    // stage 9: D^2 * 2^30 against C^2 |a|^2 |b|^2
    assign w_lhs = RW'(r_l8) << COS_SH;
    assign w_ge  = (w_lhs >= w_r8);
    assign w_le  = (w_lhs <= w_r8);

    always_comb begin
        if (r_fl[3].zero) begin
            n_angle_ok = 1'b0;
        end else if (!w_cfg.cos_dev[COS_W-1]) begin
            n_angle_ok = r_fl[3].dnonpos && w_ge;
        end else begin
            n_angle_ok = r_fl[3].dnonpos || w_le;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist_ok  <= r_fl[3].dist_ok;
        r_angle_ok <= n_angle_ok;
        r_bonded   <= r_fl[3].dist_ok & n_angle_ok;
    end

    assign o_valid    = r_out_vld;
    assign o_bonded   = r_bonded;
    assign o_dist_ok  = r_dist_ok;
    assign o_angle_ok = r_angle_ok;

    // checks
    `HBG_ASSERT_IMP(a_latency, start && !busy, ##9 o_valid)
    `HBG_ASSERT_IMP(a_no_spurious, o_valid, $past(start, 9))
    `HBG_ASSERT_IMP(a_bonded_and, o_valid, o_bonded == (o_dist_ok && o_angle_ok))
    `HBG_ASSERT_NXT(a_zero_fails, r_vld[3] && r_fl[3].zero, !o_angle_ok)

endmodule

`default_nettype wire
